FILE: hdl/rmth_pkg.sv
`timescale 1ns / 1ps
package rmth_pkg;
    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int HELD_WIDTH      = 11;
endpackage

FILE: hdl/rmth_ram.sv
`timescale 1ns / 1ps
module rmth_ram #(
    parameter int WIDTH      = 16,
    parameter int DEPTH      = 512,
    parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_WIDTH-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [ADDR_WIDTH-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/running_median_two_heaps.sv
`timescale 1ns / 1ps
// An insert pushes a value into one heap and sifts it up; when a heap top is swapped across,
// the new sample replaces the top of the other heap and sifts down from there.
// One item at a time: o_ready is high only while idle, and the two heap RAMs share one read
// address and the compare is shared. A result waits in place until it is taken.
// Reset clears both heap counts; heap storage is left unwritten and its contents past a count are never used.
module running_median_two_heaps #(
    parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = rmth_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_sample_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [VALUE_WIDTH:0]  o_median_doubled,
    output logic [rmth_pkg::HELD_WIDTH-1:0] o_items_held,
    output logic                         o_dropped
);
    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW    = $clog2(2 * DEPTH + 1);
    localparam int VW    = VALUE_WIDTH;
    localparam int HW    = rmth_pkg::HELD_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_UP_CHK = 9'b000000010,
        S_UP_CMP = 9'b000000100,
        S_UP_WR  = 9'b000001000,
        S_DN_L   = 9'b000010000,
        S_DN_LC  = 9'b000100000,
        S_DN_RC  = 9'b001000000,
        S_DN_DEC = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_lo_cnt, n_lo_cnt, r_up_cnt, n_up_cnt;
    logic signed [VW-1:0] r_lo_top, n_lo_top, r_up_top, n_up_top;
    logic          r_heap, n_heap;       // 1: lower max-heap, 0: upper min-heap
    logic [CW-1:0] r_i, n_i, r_best_idx, n_best_idx;
    logic signed [VW-1:0] r_v, n_v, r_rv, n_rv, r_best_val, n_best_val;
    logic          r_rp, n_rp, r_drop, n_drop;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic signed [VW-1:0] wdata, rd, rd_lo, rd_up;
    logic signed [VW-1:0] cmp_a, cmp_b;
    logic          above;

    logic [TW-1:0]        total;
    logic signed [VW:0]   median, d2;
    logic [CW-1:0]        act_cnt, dn_cnt;
    logic [CW:0]          child_l, child_r;
    logic [CW-1:0]        parent;
    logic [TW+HW-1:0]     held_ext;

    rmth_ram #(.WIDTH(VW), .DEPTH(DEPTH), .ADDR_WIDTH(AW)) u_lo_ram (
        .i_clk(i_clk), .i_we(we & r_heap), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_lo)
    );
    rmth_ram #(.WIDTH(VW), .DEPTH(DEPTH), .ADDR_WIDTH(AW)) u_up_ram (
        .i_clk(i_clk), .i_we(we & ~r_heap), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_up)
    );

    assign rd    = r_heap ? rd_lo : rd_up;
    assign above = r_heap ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

    assign total = TW'(r_lo_cnt) + TW'(r_up_cnt);
    always_comb begin
        if (r_lo_cnt == '0 && r_up_cnt == '0) begin
            median = '0;
        end else if (r_lo_cnt == r_up_cnt) begin
            median = {r_lo_top[VW-1], r_lo_top} + {r_up_top[VW-1], r_up_top};
        end else if (r_lo_cnt < r_up_cnt) begin
            median = {r_up_top, 1'b0};
        end else begin
            median = {r_lo_top, 1'b0};
        end
    end
    assign d2 = {i_sample_value, 1'b0};

    assign act_cnt = r_heap ? r_lo_cnt : r_up_cnt;
    assign dn_cnt  = act_cnt;
    assign child_l = {r_i, 1'b1};
    assign child_r = child_l + (CW+1)'(1);
    assign parent  = (r_i - CW'(1)) >> 1;

    assign held_ext         = {{HW{1'b0}}, total};
    assign o_items_held     = held_ext[HW-1:0];
    assign o_median_doubled = median;
    assign o_dropped        = r_drop;
    assign o_valid          = (r_state == S_OUT);
    assign o_ready          = (r_state == S_IDLE);

    always_comb begin
        logic          ph, rp, push_ok;
        logic signed [VW-1:0] pv;
        n_state    = r_state;
        n_lo_cnt   = r_lo_cnt;
        n_up_cnt   = r_up_cnt;
        n_lo_top   = r_lo_top;
        n_up_top   = r_up_top;
        n_heap     = r_heap;
        n_i        = r_i;
        n_best_idx = r_best_idx;
        n_v        = r_v;
        n_rv       = r_rv;
        n_best_val = r_best_val;
        n_rp       = r_rp;
        n_drop     = r_drop;
        we         = 1'b0;
        waddr      = r_i[AW-1:0];
        wdata      = r_v;
        raddr      = parent[AW-1:0];
        cmp_a      = r_v;
        cmp_b      = rd;
        ph         = 1'b1;
        rp         = 1'b0;
        pv         = i_sample_value;
        push_ok    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (total >= TW'(CAPACITY)) begin
                        n_drop  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_drop = 1'b0;
                        if (r_lo_cnt == '0) begin
                            ph = 1'b1;
                        end else if (r_lo_cnt == r_up_cnt) begin
                            ph = (d2 <= median);
                        end else if (r_lo_cnt < r_up_cnt) begin
                            ph = 1'b1;
                            if (d2 > median) begin
                                rp = 1'b1;
                                pv = r_up_top;
                            end
                        end else begin
                            ph = 1'b0;
                            if (d2 < median) begin
                                rp = 1'b1;
                                pv = r_lo_top;
                            end
                        end
                        n_rp = rp;
                        n_rv = i_sample_value;
                        n_v  = pv;
                        push_ok = ph ? (r_lo_cnt != CW'(DEPTH)) : (r_up_cnt != CW'(DEPTH));
                        if (push_ok) begin
                            n_heap = ph;
                            n_i    = ph ? r_lo_cnt : r_up_cnt;
                            if (ph) n_lo_cnt = r_lo_cnt + CW'(1);
                            else    n_up_cnt = r_up_cnt + CW'(1);
                            n_state = S_UP_CHK;
                        end else if (rp) begin
                            n_heap  = ~ph;
                            n_i     = '0;
                            n_v     = i_sample_value;
                            n_state = S_DN_L;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                raddr = parent[AW-1:0];
                if (r_i == '0) begin
                    n_state = S_UP_WR;
                end else begin
                    n_best_idx = parent;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmp_a = r_v;
                cmp_b = rd;
                if (above) begin
                    we      = 1'b1;
                    wdata   = rd;
                    n_i     = r_best_idx;
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                we    = 1'b1;
                wdata = r_v;
                if (r_i == '0) begin
                    if (r_heap) n_lo_top = r_v;
                    else        n_up_top = r_v;
                end
                if (r_rp) begin
                    n_heap  = ~r_heap;
                    n_i     = '0;
                    n_v     = r_rv;
                    n_state = S_DN_L;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DN_L: begin
                raddr      = child_l[AW-1:0];
                n_best_idx = r_i;
                n_best_val = r_v;
                if (child_l >= {1'b0, dn_cnt}) begin
                    n_state = S_DN_DEC;
                end else begin
                    n_state = S_DN_LC;
                end
            end
            S_DN_LC: begin
                cmp_a = rd;
                cmp_b = r_v;
                raddr = child_r[AW-1:0];
                if (above) begin
                    n_best_idx = child_l[CW-1:0];
                    n_best_val = rd;
                end
                if (child_r < {1'b0, dn_cnt}) begin
                    n_state = S_DN_RC;
                end else begin
                    n_state = S_DN_DEC;
                end
            end
            S_DN_RC: begin
                cmp_a = rd;
                cmp_b = r_best_val;
                if (above) begin
                    n_best_idx = child_r[CW-1:0];
                    n_best_val = rd;
                end
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                we = 1'b1;
                // Writes the moving value once no child outranks it, else moves the winning child up.
                wdata = (r_best_idx == r_i) ? r_v : r_best_val;
                if (r_i == '0) begin
                    if (r_heap) n_lo_top = wdata;
                    else        n_up_top = wdata;
                end
                if (r_best_idx == r_i) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = r_best_idx;
                    n_state = S_DN_L;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lo_cnt <= '0;
            r_up_cnt <= '0;
            r_drop   <= 1'b0;
            r_rp     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lo_cnt <= n_lo_cnt;
            r_up_cnt <= n_up_cnt;
            r_drop   <= n_drop;
            r_rp     <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_top   <= n_lo_top;
        r_up_top   <= n_up_top;
        r_heap     <= n_heap;
        r_i        <= n_i;
        r_best_idx <= n_best_idx;
        r_v        <= n_v;
        r_rv       <= n_rv;
        r_best_val <= n_best_val;
    end
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    localparam int VW         = rmth_pkg::VALUE_WIDTH_DEF;
    localparam int HW         = rmth_pkg::HELD_WIDTH;
    localparam int CAP        = rmth_pkg::CAPACITY_DEF;
    localparam int DEPTH      = (CAP + 1) / 2;
    localparam int N_RANDOM   = 1015;
    localparam int LIMIT      = 1000000;
    localparam int DRAIN      = 100;
    localparam bit HEAP_LOWER = 1'b0;
    localparam bit HEAP_UPPER = 1'b1;

    typedef struct packed {
        logic signed [VW:0]     median2;
        logic [HW-1:0]          held;
        logic                   dropped;
    } t_median;

    typedef struct {
        logic signed [VW-1:0] value;
        bit                   typed;
        t_median              result;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic signed [VW-1:0]   i_sample_value = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic signed [VW:0]     o_median_doubled;
    logic [HW-1:0]          o_items_held;
    logic                   o_dropped;

    running_median_two_heaps DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_value  (i_sample_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_median_doubled(o_median_doubled),
        .o_items_held    (o_items_held),
        .o_dropped       (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: index HEAP_LOWER is a max-heap, HEAP_UPPER a min-heap.
    int      heap_vals [2][DEPTH];
    int      heap_cnt  [2];
    t_median pending_medians[$];
    int      mismatches = 0;
    int      sent = 0;
    int      cycles = 0;
    bit      done = 1'b0;

    function automatic bit ranks_higher(int a, int b, bit which);
        return (which == HEAP_LOWER) ? (a > b) : (a < b);
    endfunction

    function automatic void heap_insert(bit which, int v);
        int i;
        int p;
        int t;
        i = heap_cnt[which];
        heap_vals[which][i] = v;
        heap_cnt[which] = i + 1;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!ranks_higher(heap_vals[which][i], heap_vals[which][p], which)) break;
            t = heap_vals[which][i];
            heap_vals[which][i] = heap_vals[which][p];
            heap_vals[which][p] = t;
            i = p;
        end
    endfunction

    function automatic void heap_swap_top(bit which, int v);
        int i;
        int l;
        int r;
        int best;
        int t;
        int n;
        i = 0;
        n = heap_cnt[which];
        heap_vals[which][0] = v;
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (l < n && ranks_higher(heap_vals[which][l], heap_vals[which][best], which))
                best = l;
            if (r < n && ranks_higher(heap_vals[which][r], heap_vals[which][best], which))
                best = r;
            if (best == i) break;
            t = heap_vals[which][i];
            heap_vals[which][i] = heap_vals[which][best];
            heap_vals[which][best] = t;
            i = best;
        end
    endfunction

    function automatic int current_median2();
        int lc;
        int uc;
        lc = heap_cnt[HEAP_LOWER];
        uc = heap_cnt[HEAP_UPPER];
        if (lc == 0 && uc == 0) return 0;
        if (lc == uc) return heap_vals[HEAP_LOWER][0] + heap_vals[HEAP_UPPER][0];
        if (lc < uc) return 2 * heap_vals[HEAP_UPPER][0];
        return 2 * heap_vals[HEAP_LOWER][0];
    endfunction

    function automatic t_median add_sample(logic signed [VW-1:0] sample);
        int      d;
        int      m;
        int      t;
        int      lc;
        int      uc;
        t_median r;
        d = sample;
        lc = heap_cnt[HEAP_LOWER];
        uc = heap_cnt[HEAP_UPPER];
        r.dropped = 1'b0;
        if (lc + uc >= CAP) begin
            r.dropped = 1'b1;
        end else if (lc == 0) begin
            heap_insert(HEAP_LOWER, d);
        end else begin
            m = current_median2();
            if (lc == uc) begin
                if (2 * d <= m) heap_insert(HEAP_LOWER, d);
                else heap_insert(HEAP_UPPER, d);
            end else if (lc < uc) begin
                if (2 * d > m) begin
                    t = heap_vals[HEAP_UPPER][0];
                    heap_insert(HEAP_LOWER, t);
                    heap_swap_top(HEAP_UPPER, d);
                end else begin
                    heap_insert(HEAP_LOWER, d);
                end
            end else begin
                if (2 * d < m) begin
                    t = heap_vals[HEAP_LOWER][0];
                    heap_insert(HEAP_UPPER, t);
                    heap_swap_top(HEAP_LOWER, d);
                end else begin
                    heap_insert(HEAP_UPPER, d);
                end
            end
        end
        r.median2 = (VW+1)'(current_median2());
        r.held = HW'(heap_cnt[HEAP_LOWER] + heap_cnt[HEAP_UPPER]);
        return r;
    endfunction

    // Offer one sample and hold it until the transfer completes.
    task automatic offer_sample(logic signed [VW-1:0] v, bit typed, t_median typed_result);
        t_median predicted;
        i_valid <= 1'b1;
        i_sample_value <= v;
        do @(posedge i_clk); while (!o_ready);
        predicted = add_sample(v);
        pending_medians.push_back(typed ? typed_result : predicted);
        sent++;
    endtask

    task automatic idle_gap(bit quiet);
        int n;
        n = 0;
        if (!quiet) begin
            case ($urandom_range(0, 19))
                0:           n = $urandom_range(20, 60);
                1, 2, 3, 4,
                5, 6, 7:     n = $urandom_range(1, 3);
                default:     n = 0;
            endcase
        end
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [VW-1:0] random_sample();
        case ($urandom_range(0, 19))
            0:       return {1'b0, {(VW-1){1'b1}}};
            1:       return {1'b1, {(VW-1){1'b0}}};
            2, 3, 4: return VW'($signed($urandom_range(0, 16)) - 8);
            default: return VW'($urandom_range(0, (1 << VW) - 1));
        endcase
    endfunction

    t_row rows[$];

    initial begin
        int k;
        t_median none;
        none = '0;
        rows = '{
            '{16'sh7FFF, 1'b1, '{17'sd65534, 11'd1, 1'b0}},
            '{16'sh8000, 1'b1, '{-17'sd1, 11'd2, 1'b0}},
            '{16'sh0000, 1'b1, '{17'sd0, 11'd3, 1'b0}},
            '{-16'sd1, 1'b0, '0}, '{16'sd1, 1'b0, '0},
            '{16'sh7FFF, 1'b0, '0}, '{16'sh7FFF, 1'b0, '0},
            '{16'sh8000, 1'b0, '0}, '{16'sh8000, 1'b0, '0},
            '{16'sd100, 1'b0, '0}, '{-16'sd100, 1'b0, '0},
            '{16'sh4000, 1'b0, '0}, '{16'shBFFF, 1'b0, '0},
            '{16'sd5, 1'b0, '0}, '{16'sd5, 1'b0, '0}, '{16'sd5, 1'b0, '0},
            '{16'sh5555, 1'b0, '0}, '{16'shAAAA, 1'b0, '0},
            '{16'sh00FF, 1'b0, '0}, '{16'shFF00, 1'b0, '0}
        };
        heap_cnt[HEAP_LOWER] = 0;
        heap_cnt[HEAP_UPPER] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[r]) begin
            idle_gap(1'b0);
            offer_sample(rows[r].value, rows[r].typed, rows[r].result);
        end
        // The random part runs past capacity so that the full-store case is reached.
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == 500) begin
                i_valid <= 1'b0;
                wait (pending_medians.size() == 0);
                @(posedge i_clk);
            end
            idle_gap(k >= 150 && k < 250);
            offer_sample(random_sample(), 1'b0, none);
        end
        i_valid <= 1'b0;
        wait (pending_medians.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        done = 1'b1;
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver stalls; one long hold-off keeps a result waiting in place while the next offered item is held back.
    int  hold = 0;
    bit  long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!long_hold_done && sent == 300) begin
            long_hold_done = 1'b1;
            hold = 400;
        end
        if (hold > 0) begin
            hold--;
            i_ready <= 1'b0;
        end else if (sent >= 350 && sent < 450) begin
            i_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 29))
                0:       begin hold = $urandom_range(20, 60); i_ready <= 1'b0; end
                1, 2, 3,
                4, 5, 6: i_ready <= 1'b0;
                default: i_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_median want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_medians.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: median2=%0d held=%0d dropped=%0b",
                             o_median_doubled, o_items_held, o_dropped);
            end else begin
                want = pending_medians.pop_front();
                if (want.median2 !== o_median_doubled || want.held !== o_items_held ||
                    want.dropped !== o_dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 want.median2, want.held, want.dropped,
                                 o_median_doubled, o_items_held, o_dropped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT && !done) begin
            $display("tb: failure");
            $finish;
        end
    end
endmodule

FILE: files.f
hdl/rmth_pkg.sv
hdl/rmth_ram.sv
hdl/running_median_two_heaps.sv
sim/tb_top.sv
